FILE: rtl/pscaddr_pkg.sv
// ----------------------------------------------------------------------------
// pscaddr_pkg
// Constants, types and helper functions of the polar scan-conversion address
// generator: angle reduction, CORDIC table and stage layout.
// ----------------------------------------------------------------------------
`default_nettype none

package pscaddr_pkg;

    // source image size in pixels
    localparam int IMG_WIDTH  = 1024;
    localparam int IMG_HEIGHT = 1024;

    // angle constants in 2^-20 rad
    localparam int TWO_PI_U  = 6588397;
    localparam int PI_U      = 3294199;
    localparam int HALF_PI_U = 1647100;

    // CORDIC start value, gain compensated, Q1.30
    localparam int CORDIC_GAIN = 652032874;
    localparam int CORDIC_ITER = 20;
    localparam int FRAC_BITS   = 38;

    // pipeline layout
    localparam int ST_IN     = 0;   // angle and radius products
    localparam int ST_RED0   = 1;   // first modulo step
    localparam int ST_REDN   = 6;   // last modulo step
    localparam int ST_FOLD   = 7;   // wrap to +-pi, fold to +-pi/2
    localparam int ST_COR0   = 8;   // first CORDIC stage
    localparam int ST_CORN   = 17;  // last CORDIC stage
    localparam int ST_MUL    = 18;  // cos/sin times radius, split products
    localparam int ST_SUM    = 19;  // join split products
    localparam int ST_CTR    = 20;  // add apex
    localparam int ST_OUT    = 21;  // truncate, saturate, range check
    localparam int NUM_ST    = 22;

    // configuration register indexes
    localparam logic [2:0] CFG_CENTER_X       = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y       = 3'd1;
    localparam logic [2:0] CFG_START_DISTANCE = 3'd2;
    localparam logic [2:0] CFG_DISTANCE_STEP  = 3'd3;
    localparam logic [2:0] CFG_ANGLE_START    = 3'd4;
    localparam logic [2:0] CFG_ANGLE_STEP     = 3'd5;
    localparam logic [2:0] CFG_OUT_COLS       = 3'd6;

    // fields that ride along with an item through the pipe
    typedef struct packed {
        logic [9:0]         row;
        logic [9:0]         dcol;
        logic signed [31:0] radius;
        logic               neg;
    } t_meta;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [23:0] z;
    } t_rot;

    function automatic logic signed [23:0] atan_val(input int i);
        logic signed [23:0] v;
        unique case (i)
            0:       v = 24'sd823550;
            1:       v = 24'sd486170;
            2:       v = 24'sd256879;
            3:       v = 24'sd130396;
            4:       v = 24'sd65451;
            5:       v = 24'sd32757;
            6:       v = 24'sd16383;
            7:       v = 24'sd8192;
            8:       v = 24'sd4096;
            9:       v = 24'sd2048;
            10:      v = 24'sd1024;
            11:      v = 24'sd512;
            12:      v = 24'sd256;
            13:      v = 24'sd128;
            14:      v = 24'sd64;
            15:      v = 24'sd32;
            16:      v = 24'sd16;
            17:      v = 24'sd8;
            18:      v = 24'sd4;
            default: v = 24'sd2;
        endcase
        return v;
    endfunction

    // one restoring step of the reduction modulo two pi
    function automatic logic [33:0] red_step(input logic [33:0] v, input int k);
        logic [33:0] m;
        m = 34'(TWO_PI_U) << k;
        return (v >= m) ? (v - m) : v;
    endfunction

    // one CORDIC rotation
    function automatic t_rot rot_step(input t_rot a, input int i);
        t_rot               r;
        logic signed [32:0] xs;
        logic signed [32:0] ys;
        xs = a.x >>> i;
        ys = a.y >>> i;
        if (a.z >= 0) begin
            r.x = a.x - ys;
            r.y = a.y + xs;
            r.z = a.z - atan_val(i);
        end else begin
            r.x = a.x + ys;
            r.y = a.y - xs;
            r.z = a.z + atan_val(i);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/polar_scan_conversion_address.sv
// ----------------------------------------------------------------------------
// polar_scan_conversion_address
// Maps each output pixel of a sector view to its source pixel: angle and
// radius from row and column, CORDIC cos/sin, apex offset, range flag.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | out_row, out_col
//  m_axis   | out       | dest_row, dest_col, src_x, src_y, outside
//  cfg      | in        | register index, write data
//
//  22 register stages; one request per clock unless the output stalls; each
//  result is presented by the last stage once its request has passed through.
//  Depth is set by the modulo-two-pi steps and the 20 CORDIC rotations.
//  Each stage advances when it is empty or its successor advances, so bubbles
//  close up behind a stalled output. Reset clears valid bits and restores
//  the default geometry; the config port is always ready.
`default_nettype none

module polar_scan_conversion_address (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // out_row[9:0], out_col[19:10]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // dest_row[9:0], dest_col[19:10], src_x[33:20], src_y[47:34], outside[48]
    output logic [55:0]      m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [22:0] i_cfg_data
);

    localparam int NS = pscaddr_pkg::NUM_ST;

    // configuration
    logic [19:0]        r_center_x;
    logic [19:0]        r_center_y;
    logic [19:0]        r_start_distance;
    logic signed [20:0] r_distance_step;
    logic signed [22:0] r_angle_start;
    logic signed [22:0] r_angle_step;
    logic [10:0]        r_out_cols;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x       <= 20'd67328;
            r_center_y       <= 20'd0;
            r_start_distance <= 20'd12800;
            r_distance_step  <= 21'sd256;
            r_angle_start    <= 23'sd1048576;
            r_angle_step     <= 23'sd5243;
            r_out_cols       <= 11'd200;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pscaddr_pkg::CFG_CENTER_X:       r_center_x       <= i_cfg_data[19:0];
                pscaddr_pkg::CFG_CENTER_Y:       r_center_y       <= i_cfg_data[19:0];
                pscaddr_pkg::CFG_START_DISTANCE: r_start_distance <= i_cfg_data[19:0];
                pscaddr_pkg::CFG_DISTANCE_STEP:  r_distance_step  <= i_cfg_data[20:0];
                pscaddr_pkg::CFG_ANGLE_START:    r_angle_start    <= i_cfg_data;
                pscaddr_pkg::CFG_ANGLE_STEP:     r_angle_step     <= i_cfg_data;
                pscaddr_pkg::CFG_OUT_COLS:       r_out_cols       <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // stage valids and advance enables
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || m_axis_tready;
        for (int s = NS - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // item fields carried along
    pscaddr_pkg::t_meta r_meta [NS];
    pscaddr_pkg::t_meta n_meta0;
    logic [9:0]         in_row;
    logic [9:0]         in_col;

    assign in_row = s_axis_tdata[9:0];
    assign in_col = s_axis_tdata[19:10];

    always_comb begin
        n_meta0.row    = in_row;
        n_meta0.dcol   = 10'(r_out_cols - 11'd1 - {1'b0, in_col});
        n_meta0.radius = 32'(r_start_distance) + 32'(signed'({1'b0, in_row})) *
                         32'(r_distance_step);
        n_meta0.neg    = 1'b0;
    end

    // stage 0: raw angle
    logic signed [33:0] r_ang;
    logic signed [33:0] n_ang;

    assign n_ang = 34'(r_angle_start) + 34'(signed'({1'b0, in_col})) * 34'(r_angle_step);

    always_ff @(posedge i_clk) begin
        if (en[pscaddr_pkg::ST_IN]) begin
            r_ang                      <= n_ang;
            r_meta[pscaddr_pkg::ST_IN] <= n_meta0;
        end
    end

    // stages 1..6: reduce modulo two pi, shifted positive by 1024 turns
    logic [33:0] r_red [pscaddr_pkg::ST_RED0:pscaddr_pkg::ST_REDN];
    logic [33:0] ang_pos;

    assign ang_pos = 34'(r_ang) + (34'(pscaddr_pkg::TWO_PI_U) << 10);

    always_ff @(posedge i_clk) begin
        if (en[pscaddr_pkg::ST_RED0]) begin
            r_red[pscaddr_pkg::ST_RED0]  <= pscaddr_pkg::red_step(ang_pos, 10);
            r_meta[pscaddr_pkg::ST_RED0] <= r_meta[pscaddr_pkg::ST_IN];
        end
    end

    for (genvar s = pscaddr_pkg::ST_RED0 + 1; s <= pscaddr_pkg::ST_REDN; s++) begin : g_red
        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_red[s]  <= pscaddr_pkg::red_step(
                                 pscaddr_pkg::red_step(r_red[s-1], 13 - 2 * s), 12 - 2 * s);
                r_meta[s] <= r_meta[s-1];
            end
        end
    end

    // stage 7: wrap to +-pi, fold to +-pi/2
    logic signed [23:0] r_z7;
    logic signed [23:0] wr;
    logic signed [23:0] n_z7;
    logic               n_neg;
    pscaddr_pkg::t_meta n_meta7;

    always_comb begin
        wr = signed'({1'b0, r_red[pscaddr_pkg::ST_REDN][22:0]});
        if (r_red[pscaddr_pkg::ST_REDN] >= 34'(pscaddr_pkg::PI_U)) begin
            wr = wr - 24'(pscaddr_pkg::TWO_PI_U);
        end
        n_z7  = wr;
        n_neg = 1'b0;
        priority if (wr > 24'(pscaddr_pkg::HALF_PI_U)) begin
            n_z7  = wr - 24'(pscaddr_pkg::PI_U);
            n_neg = 1'b1;
        end else if (wr < -24'(pscaddr_pkg::HALF_PI_U)) begin
            n_z7  = wr + 24'(pscaddr_pkg::PI_U);
            n_neg = 1'b1;
        end else begin
            n_neg = 1'b0;
        end
        n_meta7     = r_meta[pscaddr_pkg::ST_REDN];
        n_meta7.neg = n_neg;
    end

    always_ff @(posedge i_clk) begin
        if (en[pscaddr_pkg::ST_FOLD]) begin
            r_z7                         <= n_z7;
            r_meta[pscaddr_pkg::ST_FOLD] <= n_meta7;
        end
    end

    // stages 8..17: two CORDIC rotations each
    pscaddr_pkg::t_rot r_rot [pscaddr_pkg::ST_COR0:pscaddr_pkg::ST_CORN];
    pscaddr_pkg::t_rot rot_init;

    always_comb begin
        rot_init.x = 33'(pscaddr_pkg::CORDIC_GAIN);
        rot_init.y = '0;
        rot_init.z = r_z7;
    end

    for (genvar s = pscaddr_pkg::ST_COR0; s <= pscaddr_pkg::ST_CORN; s++) begin : g_cor
        pscaddr_pkg::t_rot rin;
        if (s == pscaddr_pkg::ST_COR0) begin : g_first
            assign rin = rot_init;
        end else begin : g_next
            assign rin = r_rot[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_rot[s]  <= pscaddr_pkg::rot_step(
                                 pscaddr_pkg::rot_step(rin, 2 * (s - pscaddr_pkg::ST_COR0)),
                                 2 * (s - pscaddr_pkg::ST_COR0) + 1);
                r_meta[s] <= r_meta[s-1];
            end
        end
    end

    // stage 18: signed cos/sin times radius, radius split in halves
    logic signed [32:0] cv;
    logic signed [32:0] sv;
    logic signed [16:0] dl;
    logic signed [15:0] dh;
    logic signed [49:0] r_pxl;
    logic signed [49:0] r_pxh;
    logic signed [49:0] r_pyl;
    logic signed [49:0] r_pyh;

    always_comb begin
        cv = r_meta[pscaddr_pkg::ST_CORN].neg ? -r_rot[pscaddr_pkg::ST_CORN].x
                                              :  r_rot[pscaddr_pkg::ST_CORN].x;
        sv = r_meta[pscaddr_pkg::ST_CORN].neg ? -r_rot[pscaddr_pkg::ST_CORN].y
                                              :  r_rot[pscaddr_pkg::ST_CORN].y;
        dl = signed'({1'b0, r_meta[pscaddr_pkg::ST_CORN].radius[15:0]});
        dh = r_meta[pscaddr_pkg::ST_CORN].radius[31:16];
    end

    always_ff @(posedge i_clk) begin
        if (en[pscaddr_pkg::ST_MUL]) begin
            r_pxl <= 50'(cv) * 50'(dl);
            r_pxh <= 50'(cv) * 50'(dh);
            r_pyl <= 50'(sv) * 50'(dl);
            r_pyh <= 50'(sv) * 50'(dh);
            r_meta[pscaddr_pkg::ST_MUL] <= r_meta[pscaddr_pkg::ST_CORN];
        end
    end

    // stage 19: join halves
    logic signed [63:0] r_tx;
    logic signed [63:0] r_ty;

    always_ff @(posedge i_clk) begin
        if (en[pscaddr_pkg::ST_SUM]) begin
            r_tx <= (64'(r_pxh) <<< 16) + 64'(r_pxl);
            r_ty <= (64'(r_pyh) <<< 16) + 64'(r_pyl);
            r_meta[pscaddr_pkg::ST_SUM] <= r_meta[pscaddr_pkg::ST_MUL];
        end
    end

    // stage 20: add apex
    logic signed [63:0] r_ux;
    logic signed [63:0] r_uy;

    always_ff @(posedge i_clk) begin
        if (en[pscaddr_pkg::ST_CTR]) begin
            r_ux <= r_tx + signed'({14'd0, r_center_x, 30'd0});
            r_uy <= r_ty + signed'({14'd0, r_center_y, 30'd0});
            r_meta[pscaddr_pkg::ST_CTR] <= r_meta[pscaddr_pkg::ST_SUM];
        end
    end

    // stage 21: truncate toward zero, saturate, range check
    localparam logic [63:0] RND = (64'd1 << pscaddr_pkg::FRAC_BITS) - 64'd1;

    logic signed [63:0] bx;
    logic signed [63:0] by;
    logic signed [25:0] qx;
    logic signed [25:0] qy;
    logic               n_out;
    logic [13:0]        n_sx;
    logic [13:0]        n_sy;
    logic [13:0]        r_sx;
    logic [13:0]        r_sy;
    logic               r_out;

    always_comb begin
        bx    = r_ux + (r_ux[63] ? signed'(RND) : 64'sd0);
        by    = r_uy + (r_uy[63] ? signed'(RND) : 64'sd0);
        qx    = bx[63:38];
        qy    = by[63:38];
        n_out = (qx < 0) || (qx >= 26'(pscaddr_pkg::IMG_WIDTH)) ||
                (qy < 0) || (qy >= 26'(pscaddr_pkg::IMG_HEIGHT));
        priority if (qx > 26'sd8191) begin
            n_sx = 14'h1FFF;
        end else if (qx < -26'sd8192) begin
            n_sx = 14'h2000;
        end else begin
            n_sx = qx[13:0];
        end
        priority if (qy > 26'sd8191) begin
            n_sy = 14'h1FFF;
        end else if (qy < -26'sd8192) begin
            n_sy = 14'h2000;
        end else begin
            n_sy = qy[13:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[pscaddr_pkg::ST_OUT]) begin
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_out <= n_out;
            r_meta[pscaddr_pkg::ST_OUT] <= r_meta[pscaddr_pkg::ST_CTR];
        end
    end

    assign m_axis_tvalid = r_v[NS-1];
    assign m_axis_tdata  = {7'd0, r_out, r_sy, r_sx,
                            r_meta[pscaddr_pkg::ST_OUT].dcol,
                            r_meta[pscaddr_pkg::ST_OUT].row};

endmodule

`default_nettype wire
